[rtl/sorted_block_merge_split_core_defines.svh]
// ----------------------------------------------------------------------------
// sorted_block_merge_split_core_defines
// Assertion macros for the merge-split core. Bodies are empty under SYNTH.
// ----------------------------------------------------------------------------
`ifndef SORTED_BLOCK_MERGE_SPLIT_CORE_DEFINES_SVH
`define SORTED_BLOCK_MERGE_SPLIT_CORE_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, sampled on clk, off during rst
`define SBMS_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, sampled on clk, off during rst
`define SBMS_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SBMS_ASSERT_IMP(name, ante, cons, msg)
`define SBMS_ASSERT_NXT(name, ante, cons, msg)
`endif

`endif

[rtl/sbms_pkg.sv]
// ----------------------------------------------------------------------------
// sbms_pkg
// Shared constants and types of the sorted block merge-split core.
// ----------------------------------------------------------------------------
package sbms_pkg;

  // Default capacity of each list store
  localparam int MAX_LEN = 64;

  // Field widths
  localparam int DATA_W = 32;
  localparam int CFG_W  = 7;

  // Reset value of the list length register
  localparam logic [CFG_W-1:0] LEN_RESET = 7'd64;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PRIME,
    ST_HEAD,
    ST_MERGE,
    ST_EMIT_PRIME,
    ST_EMIT
  } state_t;

endpackage

[rtl/sbms_in_if.sv]
// ----------------------------------------------------------------------------
// sbms_in_if
// Input channel: one local and one partner element per item.
// ----------------------------------------------------------------------------
interface sbms_in_if;
  logic                        valid;
  logic                        ready;
  logic [sbms_pkg::DATA_W-1:0] local_value;
  logic [sbms_pkg::DATA_W-1:0] partner_value;
  logic                        keep_low;
  logic                        last_in;

  modport source (
    output valid, local_value, partner_value, keep_low, last_in,
    input  ready
  );

  modport sink (
    input  valid, local_value, partner_value, keep_low, last_in,
    output ready
  );
endinterface

[rtl/sbms_out_if.sv]
// ----------------------------------------------------------------------------
// sbms_out_if
// Output channel: one kept element per item, last one flagged.
// ----------------------------------------------------------------------------
interface sbms_out_if;
  logic                        valid;
  logic                        ready;
  logic [sbms_pkg::DATA_W-1:0] kept_value;
  logic                        last_out;

  modport source (
    output valid, kept_value, last_out,
    input  ready
  );

  modport sink (
    input  valid, kept_value, last_out,
    output ready
  );
endinterface

[rtl/sorted_block_merge_split_core.sv]
// Load: one item per cycle while in ST_LOAD (input is not ready in the other
// states). Then PRIME and HEAD prime the list heads, MERGE merges the lists
// (one memory read per list per cycle), EMIT_PRIME primes the result read, and
// EMIT outputs the N kept values, holding while the output is not ready.
// rst (synchronous, active high) empties the batch and sets the list length
// to 64; the list stores are not cleared.
// ----------------------------------------------------------------------------
// sorted_block_merge_split_core
// Merge-split step: load two ascending lists into memories, merge from the
// front (keep smallest N) or back (keep largest N), emit N values ascending.
// ----------------------------------------------------------------------------
`include "sorted_block_merge_split_core_defines.svh"

module sorted_block_merge_split_core #(
  parameter int MaxLen = sbms_pkg::MAX_LEN
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [sbms_pkg::CFG_W-1:0] cfg_wdata,
  sbms_in_if.sink                    in_ch,
  sbms_out_if.source                 out_ch
);

  localparam int AW = (MaxLen > 1) ? $clog2(MaxLen) : 1;
  localparam int CW = $clog2(MaxLen + 1);
  localparam int LW = (CW > sbms_pkg::CFG_W) ? CW : sbms_pkg::CFG_W;
  localparam int DW = sbms_pkg::DATA_W;

  // Storage
  logic [DW-1:0] local_mem   [MaxLen];
  logic [DW-1:0] partner_mem [MaxLen];
  logic [DW-1:0] result_mem  [MaxLen];

  // Control registers
  sbms_pkg::state_t state, state_next;
  logic [sbms_pkg::CFG_W-1:0] list_length;
  logic [CW-1:0] count;
  logic [CW-1:0] n;
  logic [CW-1:0] cnt;
  logic [CW-1:0] e;
  logic          mode_low;
  logic          out_valid;

  // Datapath registers
  logic [AW-1:0] hl, hp, pos;
  logic [DW-1:0] lh, ph;
  logic [DW-1:0] l_rd, p_rd, r_rd;
  logic [DW-1:0] out_value;
  logic          out_last;

  // Combinational control
  logic [LW-1:0] len_w, len_eff;
  logic [CW-1:0] count_inc;
  logic          in_fire, in_done, count_room;
  logic          take_l, emit_load;
  logic [AW-1:0] start, hl_next, hp_next;
  logic [AW-1:0] l_raddr, p_raddr, r_raddr;

  function automatic logic [AW-1:0] step_idx(input logic [AW-1:0] x, input logic up);
    return up ? AW'(x + 1'b1) : AW'(x - 1'b1);
  endfunction

  // Clamp the configured length to 1..MaxLen
  always_comb begin
    len_w = LW'(list_length);
    if (len_w == '0) begin
      len_eff = LW'(1);
    end else if (len_w > LW'(MaxLen)) begin
      len_eff = LW'(MaxLen);
    end else begin
      len_eff = len_w;
    end
  end

  // Load bookkeeping
  assign count_room = (count < CW'(MaxLen));
  assign count_inc  = count_room ? CW'(count + 1'b1) : count;
  assign in_fire    = in_ch.valid && in_ch.ready;
  assign in_done    = in_ch.last_in || (LW'(count_inc) >= len_eff);

  // Merge decision and head index update
  assign start   = mode_low ? '0 : AW'(n - 1'b1);
  assign take_l  = mode_low ? ($signed(lh) < $signed(ph)) : ($signed(lh) > $signed(ph));
  assign hl_next = take_l ? step_idx(hl, mode_low) : hl;
  assign hp_next = take_l ? hp : step_idx(hp, mode_low);

  // Output register takes a new item when empty or being drained
  assign emit_load = (state == sbms_pkg::ST_EMIT) && (!out_valid || out_ch.ready) && (e < n);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      sbms_pkg::ST_LOAD: begin
        if (in_fire && in_done) state_next = sbms_pkg::ST_PRIME;
      end
      sbms_pkg::ST_PRIME:      state_next = sbms_pkg::ST_HEAD;
      sbms_pkg::ST_HEAD:       state_next = sbms_pkg::ST_MERGE;
      sbms_pkg::ST_MERGE: begin
        if (cnt == CW'(n - 1'b1)) state_next = sbms_pkg::ST_EMIT_PRIME;
      end
      sbms_pkg::ST_EMIT_PRIME: state_next = sbms_pkg::ST_EMIT;
      sbms_pkg::ST_EMIT: begin
        if (emit_load && (e == CW'(n - 1'b1))) state_next = sbms_pkg::ST_LOAD;
      end
      default:                 state_next = sbms_pkg::ST_LOAD;
    endcase
  end

  // Per-state outputs: input ready and memory read addresses
  always_comb begin
    in_ch.ready = 1'b0;
    l_raddr     = hl;
    p_raddr     = hp;
    r_raddr     = '0;
    case (state)
      sbms_pkg::ST_LOAD: begin
        in_ch.ready = 1'b1;
      end
      sbms_pkg::ST_PRIME: begin
        l_raddr = start;
        p_raddr = start;
      end
      sbms_pkg::ST_HEAD: begin
        l_raddr = step_idx(hl, mode_low);
        p_raddr = step_idx(hp, mode_low);
      end
      sbms_pkg::ST_MERGE: begin
        l_raddr = step_idx(hl_next, mode_low);
        p_raddr = step_idx(hp_next, mode_low);
      end
      sbms_pkg::ST_EMIT: begin
        r_raddr = emit_load ? AW'(e + 1'b1) : e[AW-1:0];
      end
      default: begin
        r_raddr = '0;
      end
    endcase
  end

  // List memories: write on load, registered read
  always_ff @(posedge clk) begin
    if (in_fire && count_room) begin
      local_mem[count[AW-1:0]] <= in_ch.local_value;
    end
    l_rd <= local_mem[l_raddr];
  end

  always_ff @(posedge clk) begin
    if (in_fire && count_room) begin
      partner_mem[count[AW-1:0]] <= in_ch.partner_value;
    end
    p_rd <= partner_mem[p_raddr];
  end

  // Result memory: write during merge, registered read
  always_ff @(posedge clk) begin
    if (state == sbms_pkg::ST_MERGE) begin
      result_mem[pos] <= take_l ? lh : ph;
    end
    r_rd <= result_mem[r_raddr];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= sbms_pkg::ST_LOAD;
      list_length <= sbms_pkg::LEN_RESET;
      count       <= '0;
      n           <= '0;
      cnt         <= '0;
      e           <= '0;
      mode_low    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) list_length <= cfg_wdata;

      // Count pairs; latch batch size and mode on the completing item
      if (in_fire) begin
        if (in_done) begin
          count    <= '0;
          n        <= count_inc;
          mode_low <= in_ch.keep_low;
        end else begin
          count <= count_inc;
        end
      end

      // Merge step count
      if (state == sbms_pkg::ST_PRIME) begin
        cnt <= '0;
      end else if (state == sbms_pkg::ST_MERGE) begin
        cnt <= CW'(cnt + 1'b1);
      end

      // Emit index
      if (state == sbms_pkg::ST_EMIT_PRIME) begin
        e <= '0;
      end else if (emit_load) begin
        e <= CW'(e + 1'b1);
      end

      // Output valid: set on load, drop when taken
      if (emit_load) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Merge datapath
  always_ff @(posedge clk) begin
    case (state)
      sbms_pkg::ST_PRIME: begin
        hl  <= start;
        hp  <= start;
        pos <= start;
      end
      sbms_pkg::ST_HEAD: begin
        lh <= l_rd;
        ph <= p_rd;
      end
      sbms_pkg::ST_MERGE: begin
        hl  <= hl_next;
        hp  <= hp_next;
        pos <= step_idx(pos, mode_low);
        if (take_l) begin
          lh <= l_rd;
        end else begin
          ph <= p_rd;
        end
      end
      default: begin
      end
    endcase
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_value <= r_rd;
      out_last  <= (e == CW'(n - 1'b1));
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.kept_value = out_value;
  assign out_ch.last_out   = out_last;

  // Checks
  `SBMS_ASSERT_NXT(a_done_primes, in_fire && in_done, state == sbms_pkg::ST_PRIME, "load completion did not start merge")
  `SBMS_ASSERT_IMP(a_merge_bound, state == sbms_pkg::ST_MERGE, cnt < n, "merge ran past batch size")
  `SBMS_ASSERT_IMP(a_valid_src, $rose(out_valid), $past(state) == sbms_pkg::ST_EMIT, "output item raised outside emit")
  `SBMS_ASSERT_NXT(a_last_flag, emit_load && (e == CW'(n - 1'b1)), out_last && out_valid, "final kept item not flagged")

endmodule
